// ===== design/fp32_ops_pkg.sv =====
// Package for the fp32 bit-level operations unit: opcodes, field constants, widths.
// Depends on nothing; used by the top level and the int-to-float converter.
package fp32_ops_pkg;
   localparam int unsigned OP_WIDTH   = 3;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned FRAC_BITS  = 23;
   localparam logic [7:0]  BIAS       = 8'd127;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_NEG   = 3'd0,
      OP_I2F   = 3'd1,
      OP_TWICE = 3'd2,
      OP_ABS   = 3'd3,
      OP_HALF  = 3'd4
   } op_type;

   localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
   localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [31:0] EXP_ONE   = 32'h0080_0000;
   localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_MIN_F = 32'hCF00_0000;
endpackage

// ===== design/fp32_ops_i2f.sv =====
// Combinational signed 32-bit integer to float32 converter, round to nearest even.
// Depends on fp32_ops_pkg.
module fp32_ops_i2f
   import fp32_ops_pkg::*;
(
   input  logic [31:0] value,
   output logic [31:0] result
);
   logic        sign;
   logic [31:0] mag;
   logic [4:0]  msb;
   logic [31:0] norm;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic        rnd_bit;
   logic        sticky;
   logic [23:0] frac_rnd;
   logic [7:0]  expo_rnd;

   // Magnitude and leading-one position.
   always_comb begin
      sign = value[31];
      mag  = sign ? (~value + 32'd1) : value;
      msb  = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) msb = 5'(i);
      end
   end

   // Normalize so the leading one is at bit 31, then round.
   always_comb begin
      norm     = mag << (5'd31 - msb);
      frac     = norm[30:8];
      rnd_bit  = norm[7];
      sticky   = |norm[6:0];
      expo     = {3'd0, msb} + BIAS;
      frac_rnd = {1'b0, frac} + {23'd0, rnd_bit & (sticky | frac[0])};
      expo_rnd = expo + {7'd0, frac_rnd[23]};
      if (value == 32'd0) begin
         result = 32'd0;
      end else if (value == SIGN_MASK) begin
         result = INT_MIN_F;
      end else begin
         result = {sign, expo_rnd, frac_rnd[22:0]};
      end
   end
endmodule

// ===== design/fp32_bit_level_ops_unit.sv =====
// Top level of the fp32 bit-level operations unit.
// Depends on fp32_ops_pkg and fp32_ops_i2f.
//
// Each word accepted (start high, busy low) yields one result word, registered first in
// the input register and then in the result register, with rsp_valid
// high for exactly one cycle. busy is always low, so a word may enter every
// cycle; the receiver cannot stall and must take each result as it appears.
module fp32_bit_level_ops_unit
   import fp32_ops_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   output logic [31:0] rsp_result
);
   logic        in_vld_ff;
   logic [2:0]  op_ff;
   logic [31:0] opd_ff;
   logic        out_vld_ff;
   logic [31:0] res_ff, res_in;
   logic [31:0] i2f_res;
   logic        is_nan;
   logic [31:0] twice_res, half_res;
   logic [31:0] hf;

   assign busy = 1'b0;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
      op_ff  <= req_type;
      opd_ff <= req_operand;
   end

   fp32_ops_i2f u_i2f (.value(opd_ff), .result(i2f_res));

   // Sign, scale and select logic.
   always_comb begin
      is_nan = ((opd_ff & EXP_MASK) == EXP_MASK) && ((opd_ff & FRAC_MASK) != 32'd0);
      if ((opd_ff & EXP_MASK) == EXP_MASK) begin
         twice_res = opd_ff;
      end else if ((opd_ff & EXP_MASK) == 32'd0) begin
         twice_res = (opd_ff & SIGN_MASK) | ((opd_ff << 1) & MAG_MASK);
      end else if (opd_ff[30:23] == 8'hFE) begin
         twice_res = (opd_ff & SIGN_MASK) | EXP_MASK;
      end else begin
         twice_res = opd_ff + EXP_ONE;
      end
      hf = (opd_ff & FRAC_MASK) | (opd_ff & EXP_ONE);
      if ((opd_ff & EXP_MASK) == EXP_MASK) begin
         half_res = opd_ff;
      end else if (opd_ff[30:23] > 8'd1) begin
         half_res = opd_ff - EXP_ONE;
      end else begin
         if (hf[1:0] == 2'b11) hf = hf + 32'd1;
         half_res = (opd_ff & SIGN_MASK) | (hf >> 1);
      end
      case (op_ff)
         OP_NEG:   res_in = is_nan ? opd_ff : (opd_ff ^ SIGN_MASK);
         OP_I2F:   res_in = i2f_res;
         OP_TWICE: res_in = twice_res;
         OP_ABS:   res_in = is_nan ? opd_ff : (opd_ff & MAG_MASK);
         OP_HALF:  res_in = half_res;
         default:  res_in = opd_ff;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= in_vld_ff;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_result = res_ff;

   // A word accepted shows up on the result port after the input and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("result strobe missing");
   // Negate of a non-NaN word flips only the sign.
   a_neg: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && op_ff == OP_NEG && !is_nan |=> (rsp_result ^ $past(opd_ff)) == SIGN_MASK)
      else $error("negate changed more than the sign");
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the fp32 bit-level operations unit: directed table, then random words.
// Depends on fp32_ops_pkg and the fp32_bit_level_ops_unit RTL.
module tb_top;
   import fp32_ops_pkg::*;

   localparam int RANDOM_WORDS = 1850;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = '0;
   logic [31:0] req_operand = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result;

   logic [31:0] result_queue[$];
   int          error_count = 0;
   int          idle_cycles = 0;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] operand;
      bit          known;
      logic [31:0] answer;
   } stim_row;

   stim_row stim_table[] = '{
      '{OP_I2F,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_I2F,   32'h8000_0000, 1'b1, INT_MIN_F},
      '{OP_I2F,   32'h7FFF_FFFF, 1'b1, 32'h4F00_0000},
      '{OP_I2F,   32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},
      '{OP_I2F,   32'h0100_0001, 1'b0, '0},
      '{OP_I2F,   32'h0100_0003, 1'b0, '0},
      '{OP_NEG,   32'h7FC0_0001, 1'b1, 32'h7FC0_0001},
      '{OP_NEG,   32'h0000_0000, 1'b1, 32'h8000_0000},
      '{OP_NEG,   32'hFF80_0000, 1'b1, 32'h7F80_0000},
      '{OP_ABS,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{OP_ABS,   32'h8000_0000, 1'b1, 32'h0000_0000},
      '{OP_TWICE, 32'h7F80_0000, 1'b1, 32'h7F80_0000},
      '{OP_TWICE, 32'hFFC0_0000, 1'b1, 32'hFFC0_0000},
      '{OP_TWICE, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
      '{OP_TWICE, 32'hFF00_0001, 1'b1, 32'hFF80_0000},
      '{OP_TWICE, 32'h807F_FFFF, 1'b0, '0},
      '{OP_TWICE, 32'h0040_0000, 1'b0, '0},
      '{OP_HALF,  32'hFF80_0000, 1'b1, 32'hFF80_0000},
      '{OP_HALF,  32'h0080_0000, 1'b1, 32'h0040_0000},
      '{OP_HALF,  32'h0000_0003, 1'b1, 32'h0000_0002},
      '{OP_HALF,  32'h8000_0001, 1'b1, 32'h8000_0000},
      '{OP_HALF,  32'h00FF_FFFF, 1'b0, '0},
      '{OP_HALF,  32'h7F7F_FFFF, 1'b0, '0},
      '{3'd5,     32'h1234_5678, 1'b1, 32'h1234_5678},
      '{3'd7,     32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}
   };

   fp32_bit_level_ops_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_operand(req_operand),
      .rsp_valid(rsp_valid), .rsp_result(rsp_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Signed integer to single precision, round to nearest even.
   function automatic logic [31:0] int_to_single(logic [31:0] x);
      logic        sgn;
      logic [31:0] mag;
      logic [31:0] frac;
      logic [31:0] expo;
      int          msb;
      int          sh;
      bit          round_bit;
      bit          sticky;
      sgn = x[31];
      if (x == 32'h0) return 32'h0;
      if (x == SIGN_MASK) return INT_MIN_F;
      mag = sgn ? (~x + 32'd1) : x;
      msb = 31;
      while (!mag[msb]) msb--;
      if (msb <= 23)
         return {sgn, 8'(msb + 127), 23'(mag << (23 - msb))};
      sh = msb - 23;
      frac = (mag >> sh) & FRAC_MASK;
      round_bit = mag[sh - 1];
      sticky = (mag & ((32'd1 << (sh - 1)) - 32'd1)) != 0;
      expo = 32'(msb + 127);
      if (round_bit && (sticky || frac[0])) begin
         frac++;
         if (frac[23]) begin
            expo++;
            frac = 32'd0;
         end
      end
      return {sgn, expo[7:0], frac[22:0]};
   endfunction

   // Full behavior of the unit for one word.
   function automatic logic [31:0] predict_result(logic [2:0] op, logic [31:0] v);
      logic [7:0]  ex;
      logic [24:0] sig;
      bit          nan;
      ex = v[30:23];
      nan = (ex == 8'hFF) && (v[22:0] != 0);
      case (op)
         OP_NEG:  return nan ? v : (v ^ SIGN_MASK);
         OP_ABS:  return nan ? v : (v & MAG_MASK);
         OP_I2F:  return int_to_single(v);
         OP_TWICE: begin
            if (ex == 8'hFF) return v;
            if (ex == 8'h00) return {v[31], v[29:0], 1'b0};
            if (ex == 8'hFE) return {v[31], 8'hFF, 23'h0};
            return {v[31], ex + 8'd1, v[22:0]};
         end
         OP_HALF: begin
            if (ex == 8'hFF) return v;
            if (ex > 8'd1) return {v[31], ex - 8'd1, v[22:0]};
            // Rounding up an all-ones significand carries into the exponent field.
            sig = {1'b0, ex[0], v[22:0]};
            if (sig[1:0] == 2'b11) sig++;
            return {v[31], 7'h0, sig[24:1]};
         end
         default: return v;
      endcase
   endfunction

   // Random operand shaped to hit special exponents often.
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0: v[30:23] = 8'hFF;
         1: v[30:23] = 8'h00;
         2: v[30:23] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
         3: v = v >> $urandom_range(0, 31);
         default: ;
      endcase
      return v;
   endfunction

   // Drive one word at the falling edge and hold it until accepted.
   task automatic send_word(logic [2:0] op, logic [31:0] v, bit known, logic [31:0] answer,
                            bit allow_idle);
      if (allow_idle)
         while ($urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(negedge clock);
         end
      start <= 1'b1;
      req_type <= op;
      req_operand <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      result_queue.push_back(known ? answer : predict_result(op, v));
      @(negedge clock);
   endtask

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (result_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_result);
            error_count++;
         end else begin
            logic [31:0] expected;
            expected = result_queue.pop_front();
            if (rsp_result !== expected) begin
               $display("%0t: result mismatch expected %h actual %h", $time, expected,
                        rsp_result);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word or result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [2:0] op;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (stim_table[i])
         send_word(stim_table[i].op, stim_table[i].operand, stim_table[i].known,
                   stim_table[i].answer, 1'b1);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         // A stretch in the middle runs back to back.
         send_word(op, random_operand(), 1'b0, '0, !(n >= 600 && n < 900));
      end
      start <= 1'b0;
      while (result_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/fp32_ops_pkg.sv
design/fp32_ops_i2f.sv
design/fp32_bit_level_ops_unit.sv
tb/sv/tb_top.sv
